[design/ihs_pkg.sv]
// ----------------------------------------------------------------------------
// ihs_pkg
// Shared types and constants of the image header sniffer.
// ----------------------------------------------------------------------------
package ihs_pkg;

  localparam logic [1:0] FMT_UNKNOWN = 2'd0;
  localparam logic [1:0] FMT_JPEG    = 2'd1;
  localparam logic [1:0] FMT_PNG     = 2'd2;

  localparam logic [0:0] CFG_MAX_SIDE = 1'd0;
  localparam logic [0:0] CFG_MIN_SIDE = 1'd1;

  localparam logic [15:0] MAX_SIDE_RST = 16'd2048;
  localparam logic [10:0] MIN_SIDE_RST = 11'd32;
  localparam logic [15:0] FALLBACK_SIDE = 16'd256;
  localparam logic [15:0] ROUND_LIMIT  = 16'd65520;

  localparam int unsigned OUT_TDATA_W = 112;

  // Raw header values captured on the last byte of a file
  typedef struct packed {
    logic [1:0]  fmt;
    logic [31:0] width;
    logic [31:0] height;
    logic        progressive;
    logic [7:0]  orientation;
  } ihs_info_t;

endpackage

[design/image_header_sniffer_top.sv]
// ----------------------------------------------------------------------------
// image_header_sniffer_top
// JPEG / PNG header sniffer with display size scaling.
// ----------------------------------------------------------------------------
// Usage: stream one file byte per item on the slave channel (tdata = byte,
// tlast on the final byte). One result item per file leaves on the master
// channel after the last byte. The parser takes one item per cycle whenever
// s_axis_tready_o is high; the size pipeline (halve stage, double/round
// stage, output register) registers each result before m_axis_tvalid_o.
// Throughput is one item per cycle while s_axis_tready_o is high, set by the
// parser state update. Bytes of the next file may follow the last byte at
// once. When the receiver stalls, results wait in the pipeline registers;
// ready drops only when all three hold a result and the receiver is not ready.
// Reset clears the parser to the signature check and empties the pipeline;
// max_side and min_side return to 2048 and 32. Write them on the cfg port
// (index 0 max_side, 1 min_side) only while the block is idle.
// ----------------------------------------------------------------------------
module image_header_sniffer_top import ihs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,  // [7:0] byte_value
  input  logic                   s_axis_tlast_i,  // last_byte
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [1:0] format, [33:2] frame_width, [65:34] frame_height, [66] is_progressive,
  // [74:67] orientation, [90:75] display_width, [106:91] display_height, rest 0
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_idx_i,
  input  logic [15:0]            cfg_data_i
);

  logic [15:0] max_side_q;
  logic [10:0] min_side_q;
  logic        accept;
  logic        info_valid;
  ihs_info_t   info, out_info;
  logic [15:0] disp_w, disp_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_side_q <= MAX_SIDE_RST;
      min_side_q <= MIN_SIDE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_SIDE: max_side_q <= cfg_data_i;
        CFG_MIN_SIDE: min_side_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  ihs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .info_valid_o(info_valid),
    .info_o      (info)
  );

  ihs_scaler u_scaler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_side_i  (max_side_q),
    .min_side_i  (min_side_q),
    .info_valid_i(info_valid),
    .info_i      (info),
    .ready_o     (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_info_o  (out_info),
    .disp_w_o    (disp_w),
    .disp_h_o    (disp_h)
  );

  assign m_axis_tdata_o = {5'd0, disp_h, disp_w, out_info.orientation,
                           out_info.progressive, out_info.height, out_info.width,
                           out_info.fmt};

endmodule

[design/ihs_parser.sv]
// ----------------------------------------------------------------------------
// ihs_parser
// Byte-wise header walker: signature check, JPEG markers, EXIF IFD0, PNG IHDR.
// ----------------------------------------------------------------------------
module ihs_parser import ihs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  logic [7:0] byte_i,
  input  logic      last_i,
  output logic      info_valid_o,
  output ihs_info_t info_o
);

  typedef enum logic [3:0] {
    PH_SIG, PH_MARK, PH_LEN, PH_SOF, PH_SKIPSEG, PH_XMAGIC, PH_XHDR, PH_XOFF,
    PH_SKIPIFD, PH_XCOUNT, PH_XTAG, PH_XORIENT, PH_PSKIP, PH_PCHUNK, PH_PW, PH_PH
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] shift_q, shift_d;
  logic [16:0] skip_q, skip_d;
  logic [15:0] len_q, len_d;
  logic [16:0] cons_q, cons_d;
  logic [7:0]  marker_q, marker_d;
  logic        be_q, be_d;
  logic [15:0] tags_q, tags_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic        prog_q, prog_d;
  logic [7:0]  orient_q, orient_d;
  logic [1:0]  fmt_q, fmt_d;
  logic        done_q, done_d;
  logic [3:0]  fpos_q, fpos_d;

  logic [3:0]  n;
  logic [15:0] v16;
  logic        fin_req;
  logic        is_sof;
  logic        has_len;

  always_comb begin
    phase_d  = phase_q;
    shift_d  = {shift_q[23:0], byte_i};
    skip_d   = skip_q;
    len_d    = len_q;
    cons_d   = cons_q;
    marker_d = marker_q;
    be_d     = be_q;
    tags_d   = tags_q;
    width_d  = width_q;
    height_d = height_q;
    prog_d   = prog_q;
    orient_d = orient_q;
    fmt_d    = fmt_q;
    done_d   = done_q;
    fpos_d   = fpos_q;
    fin_req  = 1'b0;
    v16      = 16'd0;
    n        = (fpos_q == 4'd15) ? 4'd15 : fpos_q + 4'd1;
    is_sof   = (marker_q[7:4] == 4'hC) && (marker_q != 8'hC4) &&
               (marker_q != 8'hC8) && (marker_q != 8'hCC);
    has_len  = ((byte_i[7:4] == 4'hC) && (byte_i != 8'hCC)) ||
               (byte_i >= 8'hDA && byte_i <= 8'hDF) || (byte_i[7:4] == 4'hE);

    if (!done_q) begin
      fpos_d = n;
      if (phase_q >= PH_SOF && phase_q <= PH_XORIENT && phase_q != PH_SKIPSEG &&
          cons_q != 17'h1FFFF) begin
        cons_d = cons_q + 17'd1;
      end
      unique case (phase_q)
        PH_SIG: begin
          if (n == 4'd2 && shift_d[15:0] == 16'hFFD8) begin
            fmt_d = FMT_JPEG; phase_d = PH_MARK; fpos_d = '0;
          end else if (n >= 4'd4) begin
            if (shift_d == 32'h89504E47) begin
              fmt_d = FMT_PNG; phase_d = PH_PSKIP; fpos_d = '0;
            end else begin
              done_d = 1'b1;
            end
          end
        end
        PH_MARK: begin
          if (n >= 4'd2) begin
            marker_d = byte_i;
            if (byte_i == 8'hD8 || byte_i == 8'hD9 || byte_i == 8'h01) begin
              phase_d = PH_MARK; fpos_d = '0;
            end else if (has_len) begin
              phase_d = PH_LEN; fpos_d = '0;
            end else begin
              done_d = 1'b1;
            end
          end
        end
        PH_LEN: begin
          if (n >= 4'd2) begin
            len_d  = shift_d[15:0];
            cons_d = 17'd2;
            if (is_sof) begin
              if (marker_q == 8'hC2 || marker_q == 8'hC6 ||
                  marker_q == 8'hCA || marker_q == 8'hCE) begin
                prog_d = 1'b1;
              end
              phase_d = PH_SOF; fpos_d = '0;
            end else if (marker_q == 8'hE1) begin
              phase_d = PH_XMAGIC; fpos_d = '0;
            end else begin
              fin_req = 1'b1;
            end
          end
        end
        PH_SOF: begin
          if (n == 4'd3) height_d = {16'd0, shift_d[15:0]};
          if (n >= 4'd5) begin
            width_d = {16'd0, shift_d[15:0]};
            fin_req = 1'b1;
          end
        end
        PH_SKIPSEG, PH_SKIPIFD: begin
          if (skip_q != '0) skip_d = skip_q - 17'd1;
          if (skip_d == '0) begin
            phase_d = (phase_q == PH_SKIPSEG) ? PH_MARK : PH_XCOUNT;
            fpos_d  = '0;
          end
        end
        PH_XMAGIC: begin
          if (n >= 4'd4) begin
            if (shift_d == 32'h45786966) begin
              phase_d = PH_XHDR; fpos_d = '0;
            end else begin
              fin_req = 1'b1;
            end
          end
        end
        PH_XHDR: begin
          if (n >= 4'd6) begin
            if (shift_d[31:16] == 16'h4D4D) begin
              be_d = 1'b1; phase_d = PH_XOFF; fpos_d = '0;
            end else if (shift_d[31:16] == 16'h4949) begin
              be_d = 1'b0; phase_d = PH_XOFF; fpos_d = '0;
            end else begin
              fin_req = 1'b1;
            end
          end
        end
        PH_XOFF: begin
          if (n >= 4'd4) begin
            v16 = be_q ? shift_d[15:0] : {shift_d[23:16], shift_d[31:24]};
            if (v16 < 16'd8) begin
              done_d = 1'b1;
            end else if (v16 == 16'd8) begin
              phase_d = PH_XCOUNT; fpos_d = '0;
            end else begin
              skip_d = {1'b0, v16} - 17'd8; phase_d = PH_SKIPIFD; fpos_d = '0;
            end
          end
        end
        PH_XCOUNT: begin
          if (n >= 4'd2) begin
            v16    = be_q ? shift_d[15:0] : {shift_d[7:0], shift_d[15:8]};
            tags_d = v16;
            if (v16 == '0) begin
              fin_req = 1'b1;
            end else begin
              phase_d = PH_XTAG; fpos_d = '0;
            end
          end
        end
        PH_XTAG: begin
          if (n == 4'd2) begin
            v16 = be_q ? shift_d[15:0] : {shift_d[7:0], shift_d[15:8]};
            if (v16 == 16'h0112) phase_d = PH_XORIENT;
          end else if (n >= 4'd12) begin
            tags_d = tags_q - 16'd1;
            if (tags_d == '0) begin
              fin_req = 1'b1;
            end else begin
              phase_d = PH_XTAG; fpos_d = '0;
            end
          end
        end
        PH_XORIENT: begin
          if (n == (be_q ? 4'd10 : 4'd9)) orient_d = byte_i;
          if (n >= 4'd12) fin_req = 1'b1;
        end
        PH_PSKIP: begin
          if (n >= 4'd8) begin
            phase_d = PH_PCHUNK; fpos_d = '0;
          end
        end
        PH_PCHUNK: begin
          if (n >= 4'd4) begin
            if (shift_d == 32'h49484452) begin
              phase_d = PH_PW; fpos_d = '0;
            end else begin
              done_d = 1'b1;
            end
          end
        end
        PH_PW: begin
          if (n >= 4'd4) begin
            width_d = shift_d; phase_d = PH_PH; fpos_d = '0;
          end
        end
        PH_PH: begin
          if (n >= 4'd4) begin
            height_d = shift_d; done_d = 1'b1;
          end
        end
        default: done_d = 1'b1;
      endcase

      // finish the segment: skip what its length leaves unread; stop if it was overrun
      if (fin_req) begin
        if (cons_d > {1'b0, len_d}) begin
          done_d = 1'b1;
        end else if (cons_d == {1'b0, len_d}) begin
          phase_d = PH_MARK; fpos_d = '0;
        end else begin
          skip_d  = {1'b0, len_d} - cons_d;
          phase_d = PH_SKIPSEG; fpos_d = '0;
        end
      end
    end
  end

  assign info_valid_o       = accept_i && last_i;
  assign info_o.fmt         = fmt_d;
  assign info_o.width       = width_d;
  assign info_o.height      = height_d;
  assign info_o.progressive = prog_d;
  assign info_o.orientation = orient_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG; shift_q <= '0; skip_q <= '0; len_q <= '0; cons_q <= '0;
      marker_q <= '0; be_q <= 1'b0; tags_q <= '0; width_q <= '0; height_q <= '0;
      prog_q <= 1'b0; orient_q <= '0; fmt_q <= FMT_UNKNOWN; done_q <= 1'b0;
      fpos_q <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        // new file starts with the next item
        phase_q <= PH_SIG; shift_q <= '0; skip_q <= '0; len_q <= '0; cons_q <= '0;
        marker_q <= '0; be_q <= 1'b0; tags_q <= '0; width_q <= '0; height_q <= '0;
        prog_q <= 1'b0; orient_q <= '0; fmt_q <= FMT_UNKNOWN; done_q <= 1'b0;
        fpos_q <= '0;
      end else begin
        phase_q <= phase_d; shift_q <= shift_d; skip_q <= skip_d; len_q <= len_d;
        cons_q <= cons_d; marker_q <= marker_d; be_q <= be_d; tags_q <= tags_d;
        width_q <= width_d; height_q <= height_d; prog_q <= prog_d;
        orient_q <= orient_d; fmt_q <= fmt_d; done_q <= done_d; fpos_q <= fpos_d;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> phase_q == PH_SIG && !done_q && fmt_q == FMT_UNKNOWN)
    else $error("parser state not cleared after last item");

  a_skip_phase_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIPSEG || phase_q == PH_SKIPIFD) && !done_q |-> skip_q != '0)
    else $error("skip phase entered with zero count");

endmodule

[design/ihs_scaler.sv]
// ----------------------------------------------------------------------------
// ihs_scaler
// Display size pipeline: halve, double, fall back, round up, output register.
// ----------------------------------------------------------------------------
module ihs_scaler import ihs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] max_side_i,
  input  logic [10:0] min_side_i,
  input  logic        info_valid_i,
  input  ihs_info_t   info_i,
  output logic        ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ihs_info_t   out_info_o,
  output logic [15:0] disp_w_o,
  output logic [15:0] disp_h_o
);

  logic        s1_v_q, s2_v_q, o_v_q;
  ihs_info_t   s1_q, s2_q, o_q;
  logic [15:0] s2_w_q, s2_h_q;
  logic        s2_zero_q;
  logic [15:0] dw_q, dh_q;
  logic        o_rdy, s2_rdy, s1_rdy;

  assign o_rdy  = !o_v_q || out_ready_i;
  assign s2_rdy = !s2_v_q || o_rdy;
  assign s1_rdy = !s1_v_q || s2_rdy;
  assign ready_o = s1_rdy;

  // halving: first shift that brings the larger side to max_side or below
  logic [31:0] m;
  logic [5:0]  ksel;
  logic [31:0] wh, hh;
  always_comb begin
    m    = (s1_q.width > s1_q.height) ? s1_q.width : s1_q.height;
    ksel = 6'd33;
    for (int k = 32; k >= 0; k--) begin
      if ((m >> k) <= {16'd0, max_side_i}) ksel = 6'(k);
    end
    wh = s1_q.width >> ksel;
    hh = s1_q.height >> ksel;
  end

  // doubling, fallback and rounding
  logic [15:0] mn;
  logic [3:0]  jsel;
  logic [27:0] w3, h3;
  logic        fall;
  logic [15:0] ws, hs;
  logic [16:0] wr, hr;
  always_comb begin
    mn   = (s2_w_q < s2_h_q) ? s2_w_q : s2_h_q;
    jsel = 4'd12;
    for (int j = 12; j >= 0; j--) begin
      if (({12'd0, mn} << j) > {17'd0, min_side_i}) jsel = 4'(j);
    end
    w3   = {12'd0, s2_w_q} << jsel;
    h3   = {12'd0, s2_h_q} << jsel;
    fall = s2_zero_q || w3 > {12'd0, max_side_i} || h3 > {12'd0, max_side_i};
    ws   = fall ? FALLBACK_SIDE : w3[15:0];
    hs   = fall ? FALLBACK_SIDE : h3[15:0];
    wr   = ({1'b0, ws} + 17'd15) & ~17'd15;
    hr   = ({1'b0, hs} + 17'd15) & ~17'd15;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= info_valid_i;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (o_rdy)  o_v_q  <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && info_valid_i) s1_q <= info_i;
    if (s2_rdy && s1_v_q) begin
      s2_q      <= s1_q;
      s2_w_q    <= wh[15:0];
      s2_h_q    <= hh[15:0];
      s2_zero_q <= (wh == '0) || (hh == '0);
    end
    if (o_rdy && s2_v_q) begin
      o_q  <= s2_q;
      dw_q <= (wr > {1'b0, ROUND_LIMIT}) ? ROUND_LIMIT : wr[15:0];
      dh_q <= (hr > {1'b0, ROUND_LIMIT}) ? ROUND_LIMIT : hr[15:0];
    end
  end

  assign out_valid_o = o_v_q;
  assign out_info_o  = o_q;
  assign disp_w_o    = dw_q;
  assign disp_h_o    = dh_q;

  a_round16: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q |-> dw_q[3:0] == 4'd0 && dh_q[3:0] == 4'd0 && dw_q != '0 && dh_q != '0)
    else $error("display size not a nonzero multiple of 16");

  a_halved_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !s2_zero_q |-> s2_w_q <= max_side_i && s2_h_q <= max_side_i)
    else $error("halved side above max_side");

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && o_rdy |=> o_v_q)
    else $error("result lost between stages");

endmodule
